[rtl/fllt_pkg.sv]
package fllt_pkg;

  localparam int unsigned DefTableDepth = 16;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned LimitW    = 8;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned VerdictW  = 2;
  localparam int unsigned FailOutW  = 5;
  localparam int unsigned MinutesW  = 27;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [LimitW-1:0] DenyLimitRst   = 8'd3;
  localparam logic [TimeW-1:0]  FailWindowRst  = 32'd900;
  localparam logic [TimeW-1:0]  UnlockDelayRst = 32'd600;
  localparam logic [TimeW-1:0]  AdminDelayRst  = 32'd600;
  localparam logic              DenyAdminRst   = 1'b0;

  // seconds to minutes: add 59, shift by 2, then divide by 15 via reciprocal
  localparam logic [5:0]       RoundUp    = 6'd59;
  localparam logic [TimeW-1:0] Recip15    = 32'h8888_8889;
  localparam int unsigned      RecipShift = 35;

  typedef enum logic [CmdW-1:0] {
    CMD_PREAUTH,
    CMD_SUCCESS,
    CMD_FAILURE,
    CMD_ACCT_OK
  } cmd_e;

  typedef enum logic [VerdictW-1:0] {
    VERD_PASS,
    VERD_LOCKED,
    VERD_RECORDED
  } verdict_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DENY_LIMIT,
    REG_FAIL_WINDOW,
    REG_UNLOCK_DELAY,
    REG_ADMIN_DELAY,
    REG_DENY_ADMIN
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_LATEST,
    ST_SCAN_COUNT,
    ST_CHECK,
    ST_MUL,
    ST_DONE
  } state_e;

endpackage

[rtl/failed_login_lockout_table.sv]
// Failed-login lockout table for one account.
// Input channel (in_valid_i / in_stall_o) carries one request: cmd_i, now_seconds_i
// and is_admin_i. Output channel (out_valid_o / out_stall_i) returns exactly one
// result per request: verdict, failure count, minutes left and status flags.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write it only while idle, the block itself does not enforce this.
// One request is processed at a time: two passes over the record memory, each
// reading every stored record through its single registered port and then
// draining and turning around, then a decision step, a multiply step for the
// minutes rounding and a commit step that loads the result. After the commit
// the block returns to idle before it accepts the next request.
// The result sits in an output register; a new request is accepted as soon
// as the previous one has been committed there, even while it is stalled.
// If the output register is still full and stalled when a result is ready, the
// block waits in its commit step and holds the table unchanged until it drains.
// Reset clears all valid bits and the record count at once (no clearing
// pass), restores the register defaults and empties the output register.
module failed_login_lockout_table import fllt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic [TimeW-1:0]    now_seconds_i,
  input  logic                is_admin_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VerdictW-1:0] verdict_o,
  output logic [FailOutW-1:0] failure_count_o,
  output logic [MinutesW-1:0] minutes_left_o,
  output logic                unlocked_by_timeout_o,
  output logic                lock_reached_o,
  output logic                table_overflow_o
);

  localparam int unsigned IdxW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AccW  = (CntW > LimitW) ? CntW : LimitW;
  localparam int unsigned QuotW = TimeW - 1;
  localparam int unsigned ProdW = QuotW + TimeW;

  state_e state_q, state_d;

  logic [LimitW-1:0] deny_limit_q;
  logic [TimeW-1:0]  fail_window_q;
  logic [TimeW-1:0]  unlock_delay_q;
  logic [TimeW-1:0]  admin_delay_q;
  logic              deny_admin_q;

  cmd_e             cmd_q, cmd_d;
  logic [TimeW-1:0] now_q, now_d;
  logic             admin_q, admin_d;

  logic [CntW-1:0] idx_q, idx_d;
  logic            p_vld_q, p_vld_d;
  logic [IdxW-1:0] p_idx_q, p_idx_d;

  logic [TimeW-1:0] mem_q [TABLE_DEPTH];
  logic [TimeW-1:0] rd_data_q;
  logic [IdxW-1:0]  rd_addr;
  logic [IdxW-1:0]  wr_addr;
  logic             mem_we;

  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [TABLE_DEPTH-1:0] aged_q, aged_d;

  logic [TimeW-1:0] latest_q, latest_d;
  logic [AccW-1:0]  fail_cnt_q, fail_cnt_d;
  logic [CntW-1:0]  remain_cnt_q, remain_cnt_d;
  logic [IdxW-1:0]  oldest_idx_q, oldest_idx_d;
  logic [TimeW-1:0] oldest_time_q, oldest_time_d;
  logic             oldest_keep_q, oldest_keep_d;

  logic             locked_q, locked_d;
  logic             unlocked_q, unlocked_d;
  logic [QuotW-1:0] quot_in_q, quot_in_d;
  logic [ProdW-1:0] prod_q, prod_d;

  logic                out_valid_q, out_valid_d;
  verdict_e            verdict_q, verdict_d;
  logic [FailOutW-1:0] fail_out_q, fail_out_d;
  logic [MinutesW-1:0] minutes_q, minutes_d;
  logic                unl_out_q, unl_out_d;
  logic                reached_q, reached_d;
  logic                overflow_q, overflow_d;

  always_comb begin
    logic [TimeW-1:0] t;
    logic             v;
    logic             stale;
    logic             exempt;
    logic             hit;
    logic             timed_out;
    logic [TimeW-1:0] delay;
    logic [TimeW:0]   target;
    logic [TimeW:0]   left;
    logic [TimeW-1:0] left_cap;
    logic [TimeW:0]   rounded;
    logic [AccW-1:0]  limit_ext;
    logic             keep_old;
    logic             take_oldest;
    logic             append;
    logic [CntW-1:0]  n_rem;
    logic [CntW-1:0]  valid_after;
    logic [IdxW-1:0]  slot;
    logic             fire;

    state_d       = state_q;
    cmd_d         = cmd_q;
    now_d         = now_q;
    admin_d       = admin_q;
    idx_d         = idx_q;
    p_vld_d       = 1'b0;
    p_idx_d       = p_idx_q;
    valid_d       = valid_q;
    cnt_d         = cnt_q;
    aged_d        = aged_q;
    latest_d      = latest_q;
    fail_cnt_d    = fail_cnt_q;
    remain_cnt_d  = remain_cnt_q;
    oldest_idx_d  = oldest_idx_q;
    oldest_time_d = oldest_time_q;
    oldest_keep_d = oldest_keep_q;
    locked_d      = locked_q;
    unlocked_d    = unlocked_q;
    quot_in_d     = quot_in_q;
    prod_d        = prod_q;
    out_valid_d   = out_valid_q;
    verdict_d     = verdict_q;
    fail_out_d    = fail_out_q;
    minutes_d     = minutes_q;
    unl_out_d     = unl_out_q;
    reached_d     = reached_q;
    overflow_d    = overflow_q;
    rd_addr       = idx_q[IdxW-1:0];
    wr_addr       = '0;
    mem_we        = 1'b0;

    t         = rd_data_q;
    v         = valid_q[p_idx_q];
    stale     = (t > now_q) || ((now_q - t) >= fail_window_q);
    exempt    = admin_q && !deny_admin_q;
    limit_ext = AccW'(deny_limit_q);
    delay     = admin_q ? admin_delay_q : unlock_delay_q;
    target    = {1'b0, latest_q} + {1'b0, delay};
    timed_out = (delay != '0) && (target < {1'b0, now_q});
    hit       = !exempt && (deny_limit_q != '0) && (fail_cnt_q >= limit_ext);
    left      = target - {1'b0, now_q};
    left_cap  = '0;
    if (target > {1'b0, now_q}) begin
      left_cap = left[TimeW] ? '1 : left[TimeW-1:0];
    end
    rounded     = {1'b0, left_cap} + (TimeW + 1)'(RoundUp);
    keep_old    = oldest_keep_q && !unlocked_q;
    n_rem       = unlocked_q ? '0 : remain_cnt_q;
    take_oldest = (cnt_q != '0) && !keep_old;
    append      = !take_oldest && (cnt_q < CntW'(TABLE_DEPTH));
    slot        = (!take_oldest && append) ? cnt_q[IdxW-1:0] : oldest_idx_q;
    valid_after = (take_oldest || append) ? n_rem + 1'b1 : n_rem;
    fire        = !out_valid_q || !out_stall_i;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d         = cmd_e'(cmd_i);
          now_d         = now_seconds_i;
          admin_d       = is_admin_i;
          idx_d         = '0;
          latest_d      = '0;
          fail_cnt_d    = '0;
          remain_cnt_d  = '0;
          aged_d        = '0;
          oldest_keep_d = 1'b0;
          state_d       = ST_SCAN_LATEST;
        end
      end
      ST_SCAN_LATEST: begin
        if (idx_q < cnt_q) begin
          p_vld_d = 1'b1;
          p_idx_d = idx_q[IdxW-1:0];
          idx_d   = idx_q + 1'b1;
        end
        if (p_vld_q && v && (t > latest_q)) begin
          latest_d = t;
        end
        if ((idx_q >= cnt_q) && !p_vld_q) begin
          idx_d   = '0;
          state_d = ST_SCAN_COUNT;
        end
      end
      ST_SCAN_COUNT: begin
        if (idx_q < cnt_q) begin
          p_vld_d = 1'b1;
          p_idx_d = idx_q[IdxW-1:0];
          idx_d   = idx_q + 1'b1;
        end
        if (p_vld_q) begin
          if (v && ((latest_q - t) < fail_window_q)) begin
            fail_cnt_d = fail_cnt_q + 1'b1;
          end
          if ((p_idx_q == '0) || (t < oldest_time_q)) begin
            oldest_idx_d  = p_idx_q;
            oldest_time_d = t;
            oldest_keep_d = v && !stale;
          end
          if (stale) begin
            aged_d[p_idx_q] = 1'b1;
          end
          if (v && !stale) begin
            remain_cnt_d = remain_cnt_q + 1'b1;
          end
        end
        if ((idx_q >= cnt_q) && !p_vld_q) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        unlocked_d = hit && timed_out;
        locked_d   = hit && !timed_out;
        quot_in_d  = rounded[TimeW:2];
        if (exempt) begin
          fail_cnt_d = '0;
        end
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = ProdW'(quot_in_q) * ProdW'(Recip15);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (fire) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          verdict_d   = locked_q ? VERD_LOCKED : VERD_PASS;
          minutes_d   = locked_q ? prod_q[RecipShift +: MinutesW] : '0;
          fail_out_d  = fail_cnt_q[FailOutW-1:0];
          unl_out_d   = unlocked_q;
          reached_d   = 1'b0;
          overflow_d  = 1'b0;
          case (cmd_q)
            CMD_SUCCESS: begin
              if (!locked_q) begin
                valid_d = '0;
                cnt_d   = '0;
              end
            end
            CMD_FAILURE: begin
              if (!locked_q) begin
                verdict_d     = VERD_RECORDED;
                valid_d       = unlocked_q ? '0 : (valid_q & ~aged_q);
                valid_d[slot] = 1'b1;
                mem_we        = 1'b1;
                wr_addr       = slot;
                if (!take_oldest && append) begin
                  cnt_d = cnt_q + 1'b1;
                end
                reached_d  = (deny_limit_q != '0) && (AccW'(valid_after) == limit_ext);
                overflow_d = !take_oldest && !append;
              end
            end
            CMD_ACCT_OK: begin
              valid_d   = '0;
              cnt_d     = '0;
              verdict_d = VERD_PASS;
              minutes_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      p_vld_q     <= 1'b0;
      valid_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      p_vld_q     <= p_vld_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deny_limit_q   <= DenyLimitRst;
      fail_window_q  <= FailWindowRst;
      unlock_delay_q <= UnlockDelayRst;
      admin_delay_q  <= AdminDelayRst;
      deny_admin_q   <= DenyAdminRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DENY_LIMIT:   deny_limit_q   <= cfg_wdata_i[LimitW-1:0];
        REG_FAIL_WINDOW:  fail_window_q  <= cfg_wdata_i[TimeW-1:0];
        REG_UNLOCK_DELAY: unlock_delay_q <= cfg_wdata_i[TimeW-1:0];
        REG_ADMIN_DELAY:  admin_delay_q  <= cfg_wdata_i[TimeW-1:0];
        REG_DENY_ADMIN:   deny_admin_q   <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    now_q         <= now_d;
    admin_q       <= admin_d;
    p_idx_q       <= p_idx_d;
    aged_q        <= aged_d;
    latest_q      <= latest_d;
    fail_cnt_q    <= fail_cnt_d;
    remain_cnt_q  <= remain_cnt_d;
    oldest_idx_q  <= oldest_idx_d;
    oldest_time_q <= oldest_time_d;
    oldest_keep_q <= oldest_keep_d;
    locked_q      <= locked_d;
    unlocked_q    <= unlocked_d;
    quot_in_q     <= quot_in_d;
    prod_q        <= prod_d;
    verdict_q     <= verdict_d;
    fail_out_q    <= fail_out_d;
    minutes_q     <= minutes_d;
    unl_out_q     <= unl_out_d;
    reached_q     <= reached_d;
    overflow_q    <= overflow_d;
  end

  // record time memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= now_q;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign in_stall_o            = (state_q != ST_IDLE);
  assign out_valid_o           = out_valid_q;
  assign verdict_o             = verdict_q;
  assign failure_count_o       = fail_out_q;
  assign minutes_left_o        = minutes_q;
  assign unlocked_by_timeout_o = unl_out_q;
  assign lock_reached_o        = reached_q;
  assign table_overflow_o      = overflow_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TABLE_DEPTH))
    else $error("record count beyond table depth");

  a_valid_below_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q >> cnt_q) == '0)
    else $error("valid record above record count");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside commit step");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SCAN_LATEST))
    else $error("accepted request did not start a scan");
`endif

endmodule

[tb/sv/failed_login_lockout_table_tb.sv]
module failed_login_lockout_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fllt_pkg::*;

  localparam int unsigned TableDepth    = DefTableDepth;
  localparam int unsigned NumRegs       = 5;
  localparam int unsigned NumPhases     = 24;
  localparam int unsigned ItemsPerPhase = 70;
  localparam int unsigned LongHold      = 400;
  localparam int unsigned LimitCycles   = 1_000_000;

  typedef struct {
    verdict_e              verdict;
    logic [FailOutW-1:0]   failures;
    logic [MinutesW-1:0]   minutes;
    logic                  unlocked;
    logic                  reached;
    logic                  overflow;
  } lockout_result_t;

  class lockout_scoreboard;
    logic [LimitW-1:0] deny_limit;
    logic [TimeW-1:0]  fail_window;
    logic [TimeW-1:0]  unlock_delay;
    logic [TimeW-1:0]  admin_delay;
    logic              deny_admin;
    logic [TimeW-1:0]  rec_time [TableDepth];
    bit                rec_valid [TableDepth];
    int unsigned       rec_count;
    lockout_result_t   expected_q [$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       locked_seen;
    int unsigned       timeouts_seen;
    int unsigned       reached_seen;
    int unsigned       overflows_seen;

    function new();
      deny_limit   = DenyLimitRst;
      fail_window  = FailWindowRst;
      unlock_delay = UnlockDelayRst;
      admin_delay  = AdminDelayRst;
      deny_admin   = DenyAdminRst;
      clear_records();
    endfunction

    function void clear_records();
      foreach (rec_valid[i]) rec_valid[i] = 1'b0;
      rec_count = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_DENY_LIMIT:   deny_limit   = data[LimitW-1:0];
        REG_FAIL_WINDOW:  fail_window  = data;
        REG_UNLOCK_DELAY: unlock_delay = data;
        REG_ADMIN_DELAY:  admin_delay  = data;
        REG_DENY_ADMIN:   deny_admin   = data[0];
        default: ;
      endcase
    endfunction

    // check, then apply the command to the record table
    function void note_request(cmd_e cmd, logic [TimeW-1:0] now_s, logic admin);
      lockout_result_t   res;
      logic [TimeW-1:0]  latest;
      longint unsigned   delay;
      longint unsigned   target;
      longint unsigned   left;
      int unsigned       fails;
      int unsigned       n;
      int unsigned       oldest;
      int unsigned       slot;
      int unsigned       live;
      bit                locked;
      bit                unlocked;
      bit                found;
      latest   = '0;
      fails    = 0;
      locked   = 1'b0;
      unlocked = 1'b0;
      found    = 1'b0;
      oldest   = 0;
      live     = 0;
      n        = rec_count;
      res.verdict  = VERD_PASS;
      res.minutes  = '0;
      res.reached  = 1'b0;
      res.overflow = 1'b0;

      if (!admin || deny_admin) begin
        for (int i = 0; i < n; i++) begin
          if (rec_valid[i] && rec_time[i] > latest) latest = rec_time[i];
        end
        for (int i = 0; i < n; i++) begin
          if (rec_valid[i] && (latest - rec_time[i]) < fail_window) fails++;
        end
        if (deny_limit != 0 && fails >= deny_limit) begin
          delay  = admin ? admin_delay : unlock_delay;
          target = longint'(latest) + delay;
          if (delay != 0 && target < longint'(now_s)) begin
            unlocked = 1'b1;
          end else begin
            locked = 1'b1;
            if (target > longint'(now_s)) begin
              left = target - longint'(now_s);
              if (left > 64'hFFFF_FFFF) left = 64'hFFFF_FFFF;
              res.minutes = MinutesW'((left + 64'd59) / 64'd60);
            end
          end
        end
      end
      res.failures = FailOutW'(fails);
      res.unlocked = unlocked;
      if (locked) res.verdict = VERD_LOCKED;
      else res.minutes = '0;

      case (cmd)
        CMD_SUCCESS: begin
          if (!locked) clear_records();
        end
        CMD_FAILURE: begin
          if (!locked) begin
            res.verdict = VERD_RECORDED;
            // age out stale or future records while finding the oldest slot
            for (int i = 0; i < n; i++) begin
              if (!found || rec_time[i] < rec_time[oldest]) begin
                oldest = i;
                found  = 1'b1;
              end
              if (unlocked || rec_time[i] > now_s || (now_s - rec_time[i]) >= fail_window)
                rec_valid[i] = 1'b0;
            end
            if (found && !rec_valid[oldest]) begin
              slot = oldest;
            end else if (n < TableDepth) begin
              slot      = n;
              rec_count = n + 1;
            end else begin
              slot         = oldest;
              res.overflow = 1'b1;
            end
            rec_time[slot]  = now_s;
            rec_valid[slot] = 1'b1;
            for (int i = 0; i < rec_count; i++) begin
              if (rec_valid[i]) live++;
            end
            res.reached = (deny_limit != 0) && (live == deny_limit);
          end
        end
        CMD_ACCT_OK: begin
          clear_records();
          res.verdict = VERD_PASS;
          res.minutes = '0;
        end
        default: ;
      endcase
      expected_q.push_back(res);
      requests++;
    endfunction

    function void compare(string field, logic [31:0] exp, logic [31:0] act);
      if (act !== exp) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp, act);
      end
    endfunction

    function void check_result(logic [VerdictW-1:0] verdict, logic [FailOutW-1:0] fails,
                               logic [MinutesW-1:0] minutes, logic unlocked,
                               logic reached, logic overflow);
      lockout_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending, verdict %0d", $time, verdict);
        return;
      end
      exp = expected_q.pop_front();
      compare("verdict", 32'(exp.verdict), 32'(verdict));
      compare("failure_count", 32'(exp.failures), 32'(fails));
      compare("minutes_left", 32'(exp.minutes), 32'(minutes));
      compare("unlocked_by_timeout", 32'(exp.unlocked), 32'(unlocked));
      compare("lock_reached", 32'(exp.reached), 32'(reached));
      compare("table_overflow", 32'(exp.overflow), 32'(overflow));
      if (exp.verdict == VERD_LOCKED) locked_seen++;
      if (exp.unlocked) timeouts_seen++;
      if (exp.reached) reached_seen++;
      if (exp.overflow) overflows_seen++;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CmdW-1:0]     cmd_i;
  logic [TimeW-1:0]    now_seconds_i;
  logic                is_admin_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [VerdictW-1:0] verdict_o;
  logic [FailOutW-1:0] failure_count_o;
  logic [MinutesW-1:0] minutes_left_o;
  logic                unlocked_by_timeout_o;
  logic                lock_reached_o;
  logic                table_overflow_o;

  lockout_scoreboard   sb = new();
  logic [CfgDataW-1:0] cfg_vals [NumRegs];
  bit                  long_hold_req;

  failed_login_lockout_table #(
    .TABLE_DEPTH(TableDepth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .cmd_i,
    .now_seconds_i,
    .is_admin_i,
    .out_valid_o,
    .out_stall_i,
    .verdict_o,
    .failure_count_o,
    .minutes_left_o,
    .unlocked_by_timeout_o,
    .lock_reached_o,
    .table_overflow_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_request(cmd_e'(cmd_i), now_seconds_i, is_admin_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result(verdict_o, failure_count_o, minutes_left_o,
                        unlocked_by_timeout_o, lock_reached_o, table_overflow_o);
    end
  end

  // result side back-pressure
  initial begin : receiver
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned stall_pct;
    hold_left = 0;
    mode_left = 0;
    stall_pct = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin
    #(20 * LimitCycles);
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_request(cmd_e cmd, logic [TimeW-1:0] now_s, logic admin);
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    now_seconds_i <= now_s;
    is_admin_i    <= admin;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_config();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_reg_e'(i);
      cfg_wdata_i <= cfg_vals[i];
      @(posedge clk_i);
      sb.write_reg(cfg_reg_e'(i), cfg_vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [LimitW-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd16;
      default: return LimitW'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [TimeW-1:0] pick_span();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(1, 2000);
    endcase
  endfunction

  function automatic cmd_e pick_cmd(int unsigned clear_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < clear_pct) return ($urandom_range(0, 1) != 0) ? CMD_SUCCESS : CMD_ACCT_OK;
    if (r < clear_pct + 35) return CMD_PREAUTH;
    return CMD_FAILURE;
  endfunction

  initial begin : stimulus
    logic [TimeW-1:0] cur_s;
    int unsigned      step_max;
    int unsigned      clear_pct;
    int unsigned      back_pct;
    int unsigned      burst_left;
    int unsigned      gap;
    int unsigned      r;
    bit               no_gaps;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_DENY_LIMIT;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    cmd_i         <= CMD_PREAUTH;
    now_seconds_i <= '0;
    is_admin_i    <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: lock after three failures, then timeout unlock
    send_request(CMD_PREAUTH, 32'd100, 1'b0);
    send_request(CMD_FAILURE, 32'd100, 1'b0);
    send_request(CMD_FAILURE, 32'd200, 1'b0);
    send_request(CMD_FAILURE, 32'd300, 1'b0);
    send_request(CMD_PREAUTH, 32'd400, 1'b0);
    send_request(CMD_SUCCESS, 32'd400, 1'b0);
    send_request(CMD_FAILURE, 32'd450, 1'b0);
    send_request(CMD_PREAUTH, 32'd900, 1'b1);
    send_request(CMD_PREAUTH, 32'd901, 1'b0);
    send_request(CMD_FAILURE, 32'd1000, 1'b0);
    send_request(CMD_ACCT_OK, 32'd1000, 1'b0);
    // lock at the top of the time range, minutes capped
    send_request(CMD_FAILURE, 32'hFFFF_FFFF, 1'b0);
    send_request(CMD_FAILURE, 32'hFFFF_FFFF, 1'b0);
    send_request(CMD_FAILURE, 32'hFFFF_FFFF, 1'b0);
    send_request(CMD_PREAUTH, 32'd0, 1'b0);
    send_request(CMD_PREAUTH, 32'hFFFF_FFFF, 1'b1);
    send_request(CMD_ACCT_OK, 32'd0, 1'b1);
    // record newer than now is aged out
    send_request(CMD_FAILURE, 32'd5000, 1'b0);
    send_request(CMD_FAILURE, 32'd4000, 1'b0);
    send_request(CMD_SUCCESS, 32'd4100, 1'b0);
    send_request(CMD_PREAUTH, 32'd4200, 1'b0);

    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_drain();
      repeat (4) @(posedge clk_i);
      case (phase)
        0: cfg_vals = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1};
        1: cfg_vals = '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
        2: cfg_vals = '{32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd1};
        3: cfg_vals = '{32'd16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0};
        default: begin
          cfg_vals[REG_DENY_LIMIT]   = {24'($urandom), pick_limit()};
          cfg_vals[REG_FAIL_WINDOW]  = pick_span();
          cfg_vals[REG_UNLOCK_DELAY] = pick_span();
          cfg_vals[REG_ADMIN_DELAY]  = pick_span();
          cfg_vals[REG_DENY_ADMIN]   = $urandom;
        end
      endcase
      set_config();

      case ($urandom_range(0, 3))
        0: step_max = 3;
        1: step_max = 60;
        2: step_max = 400;
        default: step_max = 3000;
      endcase
      case ($urandom_range(0, 3))
        0: cur_s = $urandom_range(0, 100);
        1: cur_s = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        default: cur_s = $urandom;
      endcase
      if (phase == 0) step_max = 3;
      clear_pct  = (phase == 0) ? 0 : $urandom_range(2, 20);
      back_pct   = (phase == 0) ? 0 : $urandom_range(0, 10);
      no_gaps    = (phase % 4 == 1);
      burst_left = 0;
      if (phase == 4 || phase == 13) long_hold_req = 1'b1;

      for (int k = 0; k < ItemsPerPhase; k++) begin
        r = $urandom_range(0, 99);
        if (r < back_pct) cur_s -= $urandom_range(0, step_max);
        else if (r < back_pct + 4) cur_s = $urandom;
        else cur_s += $urandom_range(0, step_max);
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap        = no_gaps ? 0 : $urandom_range(0, 8);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        if (k == ItemsPerPhase / 2 && phase % 6 == 2) wait_drain();
        burst_left--;
        send_request(pick_cmd(clear_pct), cur_s, $urandom_range(0, 4) == 0);
      end
    end

    wait_drain();
    repeat (60) @(posedge clk_i);
    $display("covered %0d requests: directed opening plus %0d register settings",
             sb.requests, NumPhases);
    $display("locked %0d, timeout unlocks %0d, lock reached %0d, table overflows %0d",
             sb.locked_seen, sb.timeouts_seen, sb.reached_seen, sb.overflows_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fllt_pkg.sv
rtl/failed_login_lockout_table.sv
tb/sv/failed_login_lockout_table_tb.sv
